// ===== rtl/rlrm_pkg.sv =====
`timescale 1ns / 1ps

package rlrm_pkg;

   // Coordinate and fixed-point sizes.
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;

   // Derived widths of the datapath.
   localparam int LEN_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * COORD_BITS + 2;
   localparam int TERM_BITS  = 2 * COORD_BITS + 1;
   localparam int AREA_BITS  = 2 * COORD_BITS + 1;
   localparam int MOM_BITS   = 3 * COORD_BITS + 1;
   localparam int CENT_BITS  = COORD_BITS + FRAC_BITS;
   localparam int CNT_BITS   = $clog2(CENT_BITS + 1);

   // Stream packing.
   localparam int REQ_FIELD_BITS = 3 * COORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 4 * COORD_BITS + AREA_BITS + 2 * CENT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS  = 2;

   // Bit positions inside rsp_tuser.
   localparam int USER_EMPTY = 0;
   localparam int USER_BAD   = 1;

   // Bit offsets inside rsp_tdata.
   localparam int RSP_AREA_LSB = 4 * COORD_BITS;
   localparam int RSP_CX_LSB   = RSP_AREA_LSB + AREA_BITS;
   localparam int RSP_CY_LSB   = RSP_CX_LSB + CENT_BITS;

   // Control from the sequencer to the accumulator datapath.
   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic clear;
   } accum_ctrl_type;

   // Running statistics of the current region.
   typedef struct packed {
      logic [COORD_BITS-1:0] min_col;
      logic [COORD_BITS-1:0] max_col;
      logic [COORD_BITS-1:0] min_row;
      logic [COORD_BITS-1:0] max_row;
      logic [AREA_BITS-1:0]  area;
      logic [MOM_BITS-1:0]   x_mom;
      logic [MOM_BITS-1:0]   y_mom;
      logic                  bad;
   } region_type;

endpackage

// ===== rtl/rlrm_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle through a single subtractor.
// Gives min(floor(num * 2^FRAC_BITS / den), all ones) over CENT_BITS bits.
// The subtractor first tests for overflow, then, if there is none, runs CENT_BITS steps.
module rlrm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rlrm_pkg::MOM_BITS-1:0]    num,
   input  logic [rlrm_pkg::AREA_BITS-1:0]   den,
   output logic                             done,
   output logic [rlrm_pkg::CENT_BITS-1:0]   quot
);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_STEP,
      DIV_FINISH
   } div_state_type;

   div_state_type                      state_ff, state_in;
   logic [rlrm_pkg::AREA_BITS-1:0]     rem_ff, rem_in;
   logic [rlrm_pkg::CENT_BITS-1:0]     dvd_ff, dvd_in;
   logic [rlrm_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [rlrm_pkg::AREA_BITS:0]       trial;
   logic [rlrm_pkg::AREA_BITS+1:0]     diff;
   logic                               ge;

   // Shared subtractor: overflow test in the check cycle, trial subtract in a step.
   always_comb begin
      if (state_ff == DIV_CHECK) begin
         trial = {1'b0, rem_ff};
      end else begin
         trial = {rem_ff, dvd_ff[rlrm_pkg::CENT_BITS-1]};
      end
      diff = {1'b0, trial} - {2'b00, den};
      ge   = ~diff[rlrm_pkg::AREA_BITS+1];
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         DIV_IDLE, DIV_FINISH: begin
            if (start) begin
               // The check state saturates the quotient unless the upper part of the numerator is below den.
               rem_in   = num[rlrm_pkg::MOM_BITS-1:rlrm_pkg::COORD_BITS];
               dvd_in   = rlrm_pkg::CENT_BITS'(num[rlrm_pkg::COORD_BITS-1:0])
                          << rlrm_pkg::FRAC_BITS;
               cnt_in   = rlrm_pkg::CNT_BITS'(rlrm_pkg::CENT_BITS);
               state_in = DIV_CHECK;
            end else begin
               state_in = DIV_IDLE;
            end
         end
         DIV_CHECK: begin
            if (ge) begin
               dvd_in   = '1;
               state_in = DIV_FINISH;
            end else begin
               state_in = DIV_STEP;
            end
         end
         DIV_STEP: begin
            if (ge) begin
               rem_in = diff[rlrm_pkg::AREA_BITS-1:0];
            end else begin
               rem_in = trial[rlrm_pkg::AREA_BITS-1:0];
            end
            dvd_in = {dvd_ff[rlrm_pkg::CENT_BITS-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == rlrm_pkg::CNT_BITS'(1)) begin
               state_in = DIV_FINISH;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign done = (state_ff == DIV_FINISH);
   assign quot = dvd_ff;

endmodule

// ===== rtl/rlrm_accum.sv =====
`timescale 1ns / 1ps

// Per-run arithmetic: run length and moment terms in one registered step,
// then saturating accumulation and box update in the next.
module rlrm_accum (
   input  logic                              clock,
   input  logic                              reset,
   input  rlrm_pkg::accum_ctrl_type          ctrl,
   input  logic [rlrm_pkg::COORD_BITS-1:0]   row,
   input  logic [rlrm_pkg::COORD_BITS-1:0]   x_start,
   input  logic [rlrm_pkg::COORD_BITS-1:0]   x_end,
   output rlrm_pkg::region_type              region
);

   logic [rlrm_pkg::LEN_BITS-1:0]    len;
   logic [rlrm_pkg::LEN_BITS-1:0]    xsum;
   logic [rlrm_pkg::PROD_BITS-1:0]   xprod;
   logic [rlrm_pkg::TERM_BITS-1:0]   yprod;
   logic [rlrm_pkg::LEN_BITS-1:0]    len_ff;
   logic [rlrm_pkg::TERM_BITS-1:0]   xm_ff;
   logic [rlrm_pkg::TERM_BITS-1:0]   ym_ff;
   logic                             bad_ff;
   logic [rlrm_pkg::AREA_BITS:0]     area_sum;
   logic [rlrm_pkg::MOM_BITS:0]      xmom_sum;
   logic [rlrm_pkg::MOM_BITS:0]      ymom_sum;
   rlrm_pkg::region_type             region_ff, region_in;

   // Run length and the two moment products.
   always_comb begin
      len   = rlrm_pkg::LEN_BITS'(x_end) - rlrm_pkg::LEN_BITS'(x_start) + 1'b1;
      xsum  = rlrm_pkg::LEN_BITS'(x_end) + rlrm_pkg::LEN_BITS'(x_start);
      xprod = rlrm_pkg::PROD_BITS'(xsum) * rlrm_pkg::PROD_BITS'(len);
      yprod = rlrm_pkg::TERM_BITS'(row) * rlrm_pkg::TERM_BITS'(len);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         len_ff <= len;
         // (xs + xe) * len is always even, so the halving is exact.
         xm_ff  <= xprod[rlrm_pkg::PROD_BITS-1:1];
         ym_ff  <= yprod;
         bad_ff <= (x_end < x_start);
      end
   end

   // Saturating sums of the accumulators.
   always_comb begin
      area_sum = {1'b0, region_ff.area} + (rlrm_pkg::AREA_BITS + 1)'(len_ff);
      xmom_sum = {1'b0, region_ff.x_mom} + (rlrm_pkg::MOM_BITS + 1)'(xm_ff);
      ymom_sum = {1'b0, region_ff.y_mom} + (rlrm_pkg::MOM_BITS + 1)'(ym_ff);
   end

   // Region update; a reversed run only raises the bad flag.
   always_comb begin
      region_in = region_ff;
      priority if (ctrl.clear) begin
         region_in.min_col = '1;
         region_in.max_col = '0;
         region_in.min_row = '1;
         region_in.max_row = '0;
         region_in.area    = '0;
         region_in.x_mom   = '0;
         region_in.y_mom   = '0;
         region_in.bad     = 1'b0;
      end else if (ctrl.acc_en) begin
         if (bad_ff) begin
            region_in.bad = 1'b1;
         end else begin
            if (x_start < region_ff.min_col) region_in.min_col = x_start;
            if (x_end > region_ff.max_col)   region_in.max_col = x_end;
            if (row < region_ff.min_row)     region_in.min_row = row;
            if (row > region_ff.max_row)     region_in.max_row = row;
            region_in.area  = area_sum[rlrm_pkg::AREA_BITS] ? '1 :
                              area_sum[rlrm_pkg::AREA_BITS-1:0];
            region_in.x_mom = xmom_sum[rlrm_pkg::MOM_BITS] ? '1 :
                              xmom_sum[rlrm_pkg::MOM_BITS-1:0];
            region_in.y_mom = ymom_sum[rlrm_pkg::MOM_BITS] ? '1 :
                              ymom_sum[rlrm_pkg::MOM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff.min_col <= '1;
         region_ff.max_col <= '0;
         region_ff.min_row <= '1;
         region_ff.max_row <= '0;
         region_ff.area    <= '0;
         region_ff.x_mom   <= '0;
         region_ff.y_mom   <= '0;
         region_ff.bad     <= 1'b0;
      end else begin
         region_ff <= region_in;
      end
   end

   assign region = region_ff;

endmodule

// ===== rtl/run_length_region_moments_core.sv =====
`timescale 1ns / 1ps

// Region moments from horizontal runs. Each request is one run (row, first
// column, last column) with tlast marking the final run of a region. An
// ordinary run passes through the length and moment products and the
// saturating accumulation, then returns to idle to take the next request. On
// the last run the block gives the bounding box, pixel area and the x and y
// centroids, each centroid coming from one shared restoring divider at one
// quotient bit per cycle, after an overflow test and before a finish state
// that hands over the quotient. The divisions are skipped when the region is
// empty and cut short when a centroid saturates; the result then waits until
// the output register is free. The input is not ready while a run is in work.
// The result sits in an output register, so the next run is taken while it
// waits; only a later result waits for it to be taken. A reversed run (last
// column below first) changes nothing but the bad flag in tuser.
module run_length_region_moments_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: row, x_start, x_end from bit 0 up, zero padded.
   input  logic [rlrm_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // rsp_tdata: box_left, box_right, box_top, box_bottom, area, centroid_x,
   // centroid_y from bit 0 up, zero padded.
   output logic [rlrm_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // rsp_tuser: empty_res, bad_run_seen from bit 0 up.
   output logic [rlrm_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DECIDE,
      ST_DIVX,
      ST_DIVY,
      ST_FIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [rlrm_pkg::COORD_BITS-1:0]    row_ff, row_in;
   logic [rlrm_pkg::COORD_BITS-1:0]    xs_ff, xs_in;
   logic [rlrm_pkg::COORD_BITS-1:0]    xe_ff, xe_in;
   logic                               last_ff, last_in;
   logic [rlrm_pkg::CENT_BITS-1:0]     cx_ff, cx_in;
   logic [rlrm_pkg::CENT_BITS-1:0]     cy_ff, cy_in;
   logic [rlrm_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [rlrm_pkg::RSP_USER_BITS-1:0] rsp_user_ff, rsp_user_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   rlrm_pkg::accum_ctrl_type           accum_ctrl;
   rlrm_pkg::region_type               region;
   logic                               req_accept;
   logic                               out_free;
   logic                               div_start;
   logic                               div_done;
   logic [rlrm_pkg::MOM_BITS-1:0]      div_num;
   logic [rlrm_pkg::CENT_BITS-1:0]     div_quot;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Accumulator datapath.
   rlrm_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (accum_ctrl),
      .row     (row_ff),
      .x_start (xs_ff),
      .x_end   (xe_ff),
      .region  (region)
   );

   // Shared divider: x centroid first, then y centroid.
   assign div_num   = (state_ff == ST_DIVX) ? region.y_mom : region.x_mom;
   assign div_start = ((state_ff == ST_DECIDE) && (region.area != '0)) ||
                      ((state_ff == ST_DIVX) && div_done);

   rlrm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (region.area),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Sequencer and result register next values.
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      xs_in        = xs_ff;
      xe_in        = xe_ff;
      last_in      = last_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      accum_ctrl   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               row_in   = req_tdata[rlrm_pkg::COORD_BITS-1:0];
               xs_in    = req_tdata[2*rlrm_pkg::COORD_BITS-1:rlrm_pkg::COORD_BITS];
               xe_in    = req_tdata[3*rlrm_pkg::COORD_BITS-1:2*rlrm_pkg::COORD_BITS];
               last_in  = req_tlast;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            accum_ctrl.mul_en = 1'b1;
            state_in          = ST_ACC;
         end
         ST_ACC: begin
            accum_ctrl.acc_en = 1'b1;
            state_in          = last_ff ? ST_DECIDE : ST_IDLE;
         end
         ST_DECIDE: begin
            // An empty region skips both divisions.
            if (region.area == '0) begin
               cx_in    = '0;
               cy_in    = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               cx_in    = div_quot;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               cy_in    = div_quot;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Load the result once the output register is free, then clear.
            if (out_free) begin
               if (region.area == '0) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = rlrm_pkg::RSP_DATA_BITS'({cy_ff, cx_ff, region.area,
                                                          region.max_row, region.min_row,
                                                          region.max_col, region.min_col});
               end
               rsp_user_in[rlrm_pkg::USER_EMPTY] = (region.area == '0);
               rsp_user_in[rlrm_pkg::USER_BAD]   = region.bad;
               rsp_valid_in     = 1'b1;
               accum_ctrl.clear = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      xs_ff       <= xs_in;
      xe_ff       <= xe_in;
      last_ff     <= last_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/rlrm_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks of the region moments core.
module rlrm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic [rlrm_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input logic                                  req_tlast,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [rlrm_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input logic [rlrm_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The input is ready only in idle, so it drops ready after a request.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a request");

   // An empty region reports all data fields as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[rlrm_pkg::USER_EMPTY] |-> rsp_tdata == '0)
      else $error("empty result with nonzero data");

   // A non-empty region has an ordered box and a nonzero area.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[rlrm_pkg::USER_EMPTY] |->
         (rsp_tdata[rlrm_pkg::COORD_BITS-1:0] <=
          rsp_tdata[2*rlrm_pkg::COORD_BITS-1:rlrm_pkg::COORD_BITS]) &&
         (rsp_tdata[3*rlrm_pkg::COORD_BITS-1:2*rlrm_pkg::COORD_BITS] <=
          rsp_tdata[4*rlrm_pkg::COORD_BITS-1:3*rlrm_pkg::COORD_BITS]) &&
         (rsp_tdata[rlrm_pkg::RSP_CX_LSB-1:rlrm_pkg::RSP_AREA_LSB] != '0))
      else $error("non-empty result with bad box or zero area");

endmodule

bind run_length_region_moments_core rlrm_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int CLOCK_HALF   = 6;
   localparam int COORD_MAX    = (1 << rlrm_pkg::COORD_BITS) - 1;
   localparam int N_DIRECTED   = 17;
   localparam int RANDOM_RUNS  = 1630;
   localparam int HOLD_AFTER   = 40;
   localparam int HOLD_CYCLES  = 600;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 100;

   typedef logic [rlrm_pkg::COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type row;
      coord_type x_start;
      coord_type x_end;
      logic      last;
   } run_type;

   typedef struct packed {
      coord_type                       box_left;
      coord_type                       box_right;
      coord_type                       box_top;
      coord_type                       box_bottom;
      logic [rlrm_pkg::AREA_BITS-1:0]  area;
      logic [rlrm_pkg::CENT_BITS-1:0]  centroid_x;
      logic [rlrm_pkg::CENT_BITS-1:0]  centroid_y;
      logic                            empty_res;
      logic                            bad_run_seen;
   } moments_type;

   typedef struct packed {
      run_type     run;
      logic        typed;
      moments_type want;
   } directed_row_type;

   localparam moments_type NO_BOX = '0;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic [rlrm_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                               req_tlast = 1'b0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [rlrm_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [rlrm_pkg::RSP_USER_BITS-1:0] rsp_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;

   // Running statistics of the region being built, as the block should hold them.
   coord_type       region_min_col = '1;
   coord_type       region_max_col = '0;
   coord_type       region_min_row = '1;
   coord_type       region_max_row = '0;
   longint unsigned region_area = 0;
   longint unsigned region_x_mom = 0;
   longint unsigned region_y_mom = 0;
   bit              region_bad = 1'b0;

   moments_type      pending_regions[$];
   directed_row_type directed_runs[N_DIRECTED];

   int failures = 0;
   int results_checked = 0;
   int runs_sent = 0;
   int reversed_runs = 0;
   int empty_regions = 0;
   int burst_left = 0;
   int idle_cycles = 0;

   int hold_left = 0;
   bit hold_done = 1'b0;
   int ready_mode = 0;
   int mode_left = 0;
   int ready_phase = 0;

   run_length_region_moments_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic run_type mk_run(int unsigned row, int unsigned xs, int unsigned xe,
                                      bit last);
      return {coord_type'(row), coord_type'(xs), coord_type'(xe), last};
   endfunction

   function automatic moments_type mk_box(int unsigned left, int unsigned right,
                                          int unsigned top, int unsigned bottom,
                                          int unsigned area, int unsigned cx,
                                          int unsigned cy, bit empty, bit bad);
      return {coord_type'(left), coord_type'(right), coord_type'(top), coord_type'(bottom),
              rlrm_pkg::AREA_BITS'(area), rlrm_pkg::CENT_BITS'(cx),
              rlrm_pkg::CENT_BITS'(cy), empty, bad};
   endfunction

   // Add that sticks at the all-ones value of a w-bit register.
   function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned add,
                                               int unsigned w);
      longint unsigned lim;
      lim = (64'd1 << w) - 1;
      if (acc > lim) acc = lim;
      if (add >= lim - acc) return lim;
      return acc + add;
   endfunction

   // Truncated fixed-point quotient, saturated to the centroid width.
   function automatic longint unsigned fixed_quot(longint unsigned num, longint unsigned den);
      longint unsigned lim;
      longint unsigned q;
      longint unsigned r;
      lim = (64'd1 << rlrm_pkg::CENT_BITS) - 1;
      if (den == 0) return 0;
      q = num / den;
      r = num % den;
      if (q > (lim >> rlrm_pkg::FRAC_BITS)) return lim;
      q = (q << rlrm_pkg::FRAC_BITS) | ((r << rlrm_pkg::FRAC_BITS) / den);
      return (q > lim) ? lim : q;
   endfunction

   // Fold one run into the region; on the final run, produce its moments and clear.
   function automatic void absorb_run(input run_type r, output bit done,
                                      output moments_type res);
      longint unsigned xs;
      longint unsigned xe;
      longint unsigned y;
      longint unsigned len;
      xs = r.x_start;
      xe = r.x_end;
      y = r.row;
      res = '0;
      done = r.last;
      if (xe < xs) begin
         region_bad = 1'b1;
      end else begin
         len = xe - xs + 1;
         if (r.x_start < region_min_col) region_min_col = r.x_start;
         if (r.x_end > region_max_col) region_max_col = r.x_end;
         if (r.row < region_min_row) region_min_row = r.row;
         if (r.row > region_max_row) region_max_row = r.row;
         region_area = sat_sum(region_area, len, rlrm_pkg::AREA_BITS);
         region_x_mom = sat_sum(region_x_mom, ((xs + xe) * len) >> 1, rlrm_pkg::MOM_BITS);
         region_y_mom = sat_sum(region_y_mom, len * y, rlrm_pkg::MOM_BITS);
      end
      if (r.last) begin
         if (region_area == 0) begin
            res.empty_res = 1'b1;
         end else begin
            res.box_left = region_min_col;
            res.box_right = region_max_col;
            res.box_top = region_min_row;
            res.box_bottom = region_max_row;
            res.area = rlrm_pkg::AREA_BITS'(region_area);
            res.centroid_x = rlrm_pkg::CENT_BITS'(fixed_quot(region_x_mom, region_area));
            res.centroid_y = rlrm_pkg::CENT_BITS'(fixed_quot(region_y_mom, region_area));
         end
         res.bad_run_seen = region_bad;
         region_min_col = '1;
         region_max_col = '0;
         region_min_row = '1;
         region_max_row = '0;
         region_area = 0;
         region_x_mom = 0;
         region_y_mom = 0;
         region_bad = 1'b0;
      end
   endfunction

   // Offer one run in bursts with random gaps, wait for the handshake, then predict.
   task automatic send_run(input run_type r, input bit typed, input moments_type want);
      int          gap;
      bit          done;
      moments_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= rlrm_pkg::REQ_DATA_BITS'({r.x_end, r.x_start, r.row});
      req_tlast <= r.last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      runs_sent++;
      if (r.x_end < r.x_start) reversed_runs++;
      absorb_run(r, done, predicted);
      if (done) begin
         if (predicted.empty_res) empty_regions++;
         pending_regions.push_back(typed ? want : predicted);
      end
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return coord_type'(COORD_MAX);
         default: return coord_type'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   // One region of stacked runs with random content; some runs are reversed.
   task automatic send_random_region();
      int      n_runs;
      int      base_row;
      int      xe;
      run_type r;
      n_runs = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      base_row = $urandom_range(0, COORD_MAX);
      for (int k = 0; k < n_runs; k++) begin
         r.row = ($urandom_range(0, 7) == 0) ? pick_coord() : coord_type'(base_row + k);
         r.x_start = pick_coord();
         case ($urandom_range(0, 9))
            0: begin
               if (r.x_start == 0) r.x_start = coord_type'($urandom_range(1, COORD_MAX));
               r.x_end = coord_type'($urandom_range(0, r.x_start - 1));
            end
            1: r.x_end = pick_coord();
            default: begin
               xe = int'(r.x_start) + $urandom_range(0, 64);
               r.x_end = coord_type'((xe > COORD_MAX) ? COORD_MAX : xe);
            end
         endcase
         r.last = (k == n_runs - 1);
         send_run(r, 1'b0, NO_BOX);
      end
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Compare each accepted result with the oldest predicted region.
   always @(posedge clock) begin
      moments_type got;
      moments_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.box_left = rsp_tdata[0 +: rlrm_pkg::COORD_BITS];
         got.box_right = rsp_tdata[rlrm_pkg::COORD_BITS +: rlrm_pkg::COORD_BITS];
         got.box_top = rsp_tdata[2 * rlrm_pkg::COORD_BITS +: rlrm_pkg::COORD_BITS];
         got.box_bottom = rsp_tdata[3 * rlrm_pkg::COORD_BITS +: rlrm_pkg::COORD_BITS];
         got.area = rsp_tdata[rlrm_pkg::RSP_AREA_LSB +: rlrm_pkg::AREA_BITS];
         got.centroid_x = rsp_tdata[rlrm_pkg::RSP_CX_LSB +: rlrm_pkg::CENT_BITS];
         got.centroid_y = rsp_tdata[rlrm_pkg::RSP_CY_LSB +: rlrm_pkg::CENT_BITS];
         got.empty_res = rsp_tuser[rlrm_pkg::USER_EMPTY];
         got.bad_run_seen = rsp_tuser[rlrm_pkg::USER_BAD];
         if (pending_regions.size() == 0) begin
            $error("result with no region pending: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = pending_regions.pop_front();
            check_field("box_left", want.box_left, got.box_left);
            check_field("box_right", want.box_right, got.box_right);
            check_field("box_top", want.box_top, got.box_top);
            check_field("box_bottom", want.box_bottom, got.box_bottom);
            check_field("area", want.area, got.area);
            check_field("centroid_x", want.centroid_x, got.centroid_x);
            check_field("centroid_y", want.centroid_y, got.centroid_y);
            check_field("empty_res", want.empty_res, got.empty_res);
            check_field("bad_run_seen", want.bad_run_seen, got.bad_run_seen);
         end
         results_checked <= results_checked + 1;
      end
   end

   // Result-side backpressure: changing stall modes, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
         rsp_tready <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(8, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         ready_phase <= ready_phase + 1;
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (ready_phase % 5 != 0);
         endcase
      end
   end

   // Watchdog on cycles in which neither side moves a request.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a request moving", idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Extremes, reversed and empty regions, and multi-row regions.
      directed_runs = '{
         {mk_run(0, 0, 0, 1), 1'b1, mk_box(0, 0, 0, 0, 1, 0, 0, 0, 0)},
         {mk_run(4095, 4095, 4095, 1), 1'b1,
          mk_box(4095, 4095, 4095, 4095, 1, 20'hFFF00, 20'hFFF00, 0, 0)},
         {mk_run(4095, 0, 4095, 1), 1'b1,
          mk_box(0, 4095, 4095, 4095, 4096, 20'h7FF80, 20'hFFF00, 0, 0)},
         {mk_run(7, 100, 50, 1), 1'b1, mk_box(0, 0, 0, 0, 0, 0, 0, 1, 1)},
         {mk_run(1, 2, 1, 0), 1'b0, NO_BOX},
         {mk_run(2, 3, 2, 1), 1'b1, mk_box(0, 0, 0, 0, 0, 0, 0, 1, 1)},
         {mk_run(3, 4095, 0, 0), 1'b0, NO_BOX},
         {mk_run(3, 10, 20, 1), 1'b0, NO_BOX},
         {mk_run(10, 5, 15, 0), 1'b0, NO_BOX},
         {mk_run(11, 3, 20, 0), 1'b0, NO_BOX},
         {mk_run(12, 8, 9, 1), 1'b0, NO_BOX},
         {mk_run(0, 0, 4095, 0), 1'b0, NO_BOX},
         {mk_run(0, 1, 0, 0), 1'b0, NO_BOX},
         {mk_run(4095, 4095, 4095, 1), 1'b0, NO_BOX},
         {mk_run(12'hAAA, 12'h555, 12'hAAA, 0), 1'b0, NO_BOX},
         {mk_run(12'h555, 12'h555, 12'h555, 1), 1'b0, NO_BOX},
         {mk_run(12'h800, 12'h7FF, 12'h800, 1), 1'b0, NO_BOX}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_runs[i])
         send_run(directed_runs[i].run, directed_runs[i].typed, directed_runs[i].want);

      while (runs_sent < N_DIRECTED + RANDOM_RUNS) send_random_region();
      req_tvalid <= 1'b0;

      while (pending_regions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_regions.size() != 0) begin
         $error("%0d regions never produced a result", pending_regions.size());
         failures++;
      end
      $display("Sent %0d runs (%0d reversed), checked %0d regions, %0d of them empty.",
               runs_sent, reversed_runs, results_checked, empty_regions);
      $display("Both sides stalled at random, with one long output hold-off.");
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
